FILE: rtl/core/q12mvt_pkg.sv
// Shared widths, register map and item flag type for the 3x3 Q4.12
// matrix-vector transform. No dependencies.
`default_nettype none

package q12mvt_pkg;

  localparam int unsigned DataW  = 32;  // vector components and results
  localparam int unsigned CoefW  = 16;  // one signed 4.12 coefficient
  localparam int unsigned RowW   = 3 * CoefW;
  localparam int unsigned ShortW = 16;  // short-result wrap width
  localparam int unsigned FracW  = 12;  // fraction bits dropped after the dot product
  localparam int unsigned ProdW  = DataW + CoefW;

  // APB: 64-bit data, registers on 8-byte strides
  localparam int unsigned PDataW = 64;
  localparam int unsigned PAddrW = 6;
  localparam int unsigned IdxLsb = 3;
  localparam int unsigned IdxW   = PAddrW - IdxLsb;

  typedef enum logic [IdxW-1:0] {
    RegRow0   = 3'd0,
    RegRow1   = 3'd1,
    RegRow2   = 3'd2,
    RegTransX = 3'd3,
    RegTransY = 3'd4,
    RegTransZ = 3'd5
  } reg_idx_e;

  // identity matrix after reset
  localparam logic [RowW-1:0] Row0Reset = 48'h0000_0000_1000;
  localparam logic [RowW-1:0] Row1Reset = 48'h0000_1000_0000;
  localparam logic [RowW-1:0] Row2Reset = 48'h1000_0000_0000;

  typedef struct packed {
    logic add_translation;
    logic short_result;
  } item_flags_t;

endpackage

`default_nettype wire

FILE: rtl/core/q12mvt_row.sv
// One matrix row: dot product with the vector, arithmetic shift, optional
// translation and 16-bit wrap. Depends on q12mvt_pkg.
`default_nettype none

module q12mvt_row (
  input  logic [q12mvt_pkg::RowW-1:0]  coeffs_i,
  input  logic [q12mvt_pkg::DataW-1:0] vec_x_i,
  input  logic [q12mvt_pkg::DataW-1:0] vec_y_i,
  input  logic [q12mvt_pkg::DataW-1:0] vec_z_i,
  input  logic [q12mvt_pkg::DataW-1:0] trans_i,
  input  q12mvt_pkg::item_flags_t      flags_i,
  output logic [q12mvt_pkg::DataW-1:0] result_o
);

  logic [q12mvt_pkg::ProdW-1:0] prod0, prod1, prod2;
  logic [q12mvt_pkg::DataW-1:0] acc, shifted, sum_t;

  // only the low 32 bits of each product matter: everything wraps mod 2^32
  assign prod0 = $signed(coeffs_i[q12mvt_pkg::CoefW-1:0]) * $signed(vec_x_i);
  assign prod1 = $signed(coeffs_i[2*q12mvt_pkg::CoefW-1:q12mvt_pkg::CoefW]) * $signed(vec_y_i);
  assign prod2 = $signed(coeffs_i[3*q12mvt_pkg::CoefW-1:2*q12mvt_pkg::CoefW]) * $signed(vec_z_i);

  always_comb begin
    acc     = prod0[q12mvt_pkg::DataW-1:0] + prod1[q12mvt_pkg::DataW-1:0]
            + prod2[q12mvt_pkg::DataW-1:0];
    shifted = $unsigned($signed(acc) >>> q12mvt_pkg::FracW);
    sum_t   = flags_i.add_translation ? shifted + trans_i : shifted;
    if (flags_i.short_result) begin
      result_o = {{(q12mvt_pkg::DataW-q12mvt_pkg::ShortW){sum_t[q12mvt_pkg::ShortW-1]}},
                  sum_t[q12mvt_pkg::ShortW-1:0]};
    end else begin
      result_o = sum_t;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/q12_matrix_vector_transform.sv
// Top level of the 3x3 Q4.12 matrix-vector transform: APB register file,
// input register, three row units, result register. Uses q12mvt_pkg, q12mvt_row.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------------
//   in       | in_valid_i / in_stall_o    | in_x/y/z_i, add_translation_i,
//            |                            | short_result_i
//   out      | out_valid_o / out_stall_i  | out_x/y/z_o
//   cfg      | psel/penable/pwrite/pready | paddr, pwdata, prdata (64 bit)
//
// One item per cycle sustained while out_stall_i is low. An accepted item passes
// through the input register, then nine parallel multipliers, into the result
// register, which drives out_valid_o. While a result waits under out_stall_i the
// input register takes at most one more item, then in_stall_o rises.
// Reset loads the identity matrix and zero translation; no clearing pass.
`default_nettype none

module q12_matrix_vector_transform (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input items
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [q12mvt_pkg::DataW-1:0]   in_x_i,
  input  logic [q12mvt_pkg::DataW-1:0]   in_y_i,
  input  logic [q12mvt_pkg::DataW-1:0]   in_z_i,
  input  logic                           add_translation_i,
  input  logic                           short_result_i,
  // result items
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [q12mvt_pkg::DataW-1:0]   out_x_o,
  output logic [q12mvt_pkg::DataW-1:0]   out_y_o,
  output logic [q12mvt_pkg::DataW-1:0]   out_z_o,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [q12mvt_pkg::PAddrW-1:0]  paddr,
  input  logic [q12mvt_pkg::PDataW-1:0]  pwdata,
  output logic [q12mvt_pkg::PDataW-1:0]  prdata,
  output logic                           pready
);

  logic [q12mvt_pkg::RowW-1:0]  row0_q, row1_q, row2_q;
  logic [q12mvt_pkg::DataW-1:0] trans_x_q, trans_y_q, trans_z_q;
  logic                         cfg_wr;
  q12mvt_pkg::reg_idx_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = q12mvt_pkg::reg_idx_e'(paddr[q12mvt_pkg::PAddrW-1:q12mvt_pkg::IdxLsb]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row0_q    <= q12mvt_pkg::Row0Reset;
      row1_q    <= q12mvt_pkg::Row1Reset;
      row2_q    <= q12mvt_pkg::Row2Reset;
      trans_x_q <= '0;
      trans_y_q <= '0;
      trans_z_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        q12mvt_pkg::RegRow0:   row0_q    <= pwdata[q12mvt_pkg::RowW-1:0];
        q12mvt_pkg::RegRow1:   row1_q    <= pwdata[q12mvt_pkg::RowW-1:0];
        q12mvt_pkg::RegRow2:   row2_q    <= pwdata[q12mvt_pkg::RowW-1:0];
        q12mvt_pkg::RegTransX: trans_x_q <= pwdata[q12mvt_pkg::DataW-1:0];
        q12mvt_pkg::RegTransY: trans_y_q <= pwdata[q12mvt_pkg::DataW-1:0];
        q12mvt_pkg::RegTransZ: trans_z_q <= pwdata[q12mvt_pkg::DataW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      q12mvt_pkg::RegRow0:   prdata = {{(q12mvt_pkg::PDataW-q12mvt_pkg::RowW){1'b0}}, row0_q};
      q12mvt_pkg::RegRow1:   prdata = {{(q12mvt_pkg::PDataW-q12mvt_pkg::RowW){1'b0}}, row1_q};
      q12mvt_pkg::RegRow2:   prdata = {{(q12mvt_pkg::PDataW-q12mvt_pkg::RowW){1'b0}}, row2_q};
      q12mvt_pkg::RegTransX: prdata = {{(q12mvt_pkg::PDataW-q12mvt_pkg::DataW){1'b0}}, trans_x_q};
      q12mvt_pkg::RegTransY: prdata = {{(q12mvt_pkg::PDataW-q12mvt_pkg::DataW){1'b0}}, trans_y_q};
      q12mvt_pkg::RegTransZ: prdata = {{(q12mvt_pkg::PDataW-q12mvt_pkg::DataW){1'b0}}, trans_z_q};
      default:               prdata = '0;
    endcase
  end

  // two-stage flow: input register, then result register
  logic                         in_valid_q, out_valid_q;
  logic                         in_valid_d, out_valid_d;
  logic                         out_ready, in_ready, in_accept;
  logic [q12mvt_pkg::DataW-1:0] x_q, y_q, z_q;
  q12mvt_pkg::item_flags_t      flags_q;
  logic [q12mvt_pkg::DataW-1:0] res_x, res_y, res_z;
  logic [q12mvt_pkg::DataW-1:0] out_x_q, out_y_q, out_z_q;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_ready   = !in_valid_q || out_ready;
  assign in_accept  = in_valid_i && in_ready;
  assign in_stall_o = !in_ready;

  assign in_valid_d  = in_accept ? 1'b1 : (out_ready ? 1'b0 : in_valid_q);
  assign out_valid_d = out_ready ? in_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      x_q                     <= in_x_i;
      y_q                     <= in_y_i;
      z_q                     <= in_z_i;
      flags_q.add_translation <= add_translation_i;
      flags_q.short_result    <= short_result_i;
    end
    if (out_ready && in_valid_q) begin
      out_x_q <= res_x;
      out_y_q <= res_y;
      out_z_q <= res_z;
    end
  end

  q12mvt_row u_row_x (
    .coeffs_i (row0_q),
    .vec_x_i  (x_q),
    .vec_y_i  (y_q),
    .vec_z_i  (z_q),
    .trans_i  (trans_x_q),
    .flags_i  (flags_q),
    .result_o (res_x)
  );

  q12mvt_row u_row_y (
    .coeffs_i (row1_q),
    .vec_x_i  (x_q),
    .vec_y_i  (y_q),
    .vec_z_i  (z_q),
    .trans_i  (trans_y_q),
    .flags_i  (flags_q),
    .result_o (res_y)
  );

  q12mvt_row u_row_z (
    .coeffs_i (row2_q),
    .vec_x_i  (x_q),
    .vec_y_i  (y_q),
    .vec_z_i  (z_q),
    .trans_i  (trans_z_q),
    .flags_i  (flags_q),
    .result_o (res_z)
  );

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_z_o     = out_z_q;

endmodule

`default_nettype wire

FILE: rtl/core/q12mvt_checker.sv
// Port-level checks for q12_matrix_vector_transform, bound to the top level.
// Uses q12mvt_pkg.
`default_nettype none

module q12mvt_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_o,
  input  logic                           out_valid_o,
  input  logic                           out_stall_i,
  input  logic [q12mvt_pkg::DataW-1:0]   out_x_o,
  input  logic [q12mvt_pkg::DataW-1:0]   out_y_o,
  input  logic [q12mvt_pkg::DataW-1:0]   out_z_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [q12mvt_pkg::PAddrW-1:0]  paddr,
  input  logic [q12mvt_pkg::PDataW-1:0]  pwdata,
  input  logic [q12mvt_pkg::PDataW-1:0]  prdata
);

  logic [q12mvt_pkg::IdxW-1:0] wr_idx;
  logic                        wr_trans;

  assign wr_idx   = paddr[q12mvt_pkg::PAddrW-1:q12mvt_pkg::IdxLsb];
  assign wr_trans = (wr_idx == q12mvt_pkg::RegTransX) || (wr_idx == q12mvt_pkg::RegTransY)
                    || (wr_idx == q12mvt_pkg::RegTransZ);

  // a held result keeps its values
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_x_o)
      && $stable(out_y_o) && $stable(out_z_o))
    else $error("result changed while stalled");

  // input only stalls when a result is blocked downstream
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with free output");

  // a result that appears from empty traces back to an accepted item
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without matching item");

  // a translation register reads back what was just written
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && wr_trans
    |=> (psel && !pwrite && paddr == $past(paddr))
      |-> prdata == {{(q12mvt_pkg::PDataW-q12mvt_pkg::DataW){1'b0}},
                     $past(pwdata[q12mvt_pkg::DataW-1:0])})
    else $error("register readback mismatch");

endmodule

bind q12_matrix_vector_transform q12mvt_checker u_q12mvt_checker (.*);

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for q12_matrix_vector_transform: a 3x3 Q4.12
// matrix times a 32-bit vector, with optional translation and 16-bit wrap.
// Depends on q12mvt_pkg and the block's RTL only.

module tb_top;

  localparam int unsigned DataW  = q12mvt_pkg::DataW;
  localparam int unsigned CoefW  = q12mvt_pkg::CoefW;
  localparam int unsigned RowW   = q12mvt_pkg::RowW;
  localparam int unsigned ShortW = q12mvt_pkg::ShortW;
  localparam int unsigned FracW  = q12mvt_pkg::FracW;
  localparam int unsigned PDataW = q12mvt_pkg::PDataW;
  localparam int unsigned PAddrW = q12mvt_pkg::PAddrW;
  localparam int unsigned IdxLsb = q12mvt_pkg::IdxLsb;
  localparam int unsigned IdxW   = q12mvt_pkg::IdxW;

  localparam int unsigned StallLimit = 1000;  // cycles without any transfer
  localparam int unsigned RandomItems = 1400;
  localparam int unsigned SteadyItems = 200;

  typedef struct packed {
    logic [DataW-1:0]        x;
    logic [DataW-1:0]        y;
    logic [DataW-1:0]        z;
    q12mvt_pkg::item_flags_t flags;
  } vec_item_t;

  typedef struct packed {
    logic [DataW-1:0] x;
    logic [DataW-1:0] y;
    logic [DataW-1:0] z;
  } vec_out_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [DataW-1:0]  in_x_i;
  logic [DataW-1:0]  in_y_i;
  logic [DataW-1:0]  in_z_i;
  logic              add_translation_i;
  logic              short_result_i;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [DataW-1:0]  out_x_o;
  logic [DataW-1:0]  out_y_o;
  logic [DataW-1:0]  out_z_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PAddrW-1:0] paddr;
  logic [PDataW-1:0] pwdata;
  logic [PDataW-1:0] prdata;
  logic              pready;

  q12_matrix_vector_transform u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_x_i            (in_x_i),
    .in_y_i            (in_y_i),
    .in_z_i            (in_z_i),
    .add_translation_i (add_translation_i),
    .short_result_i    (short_result_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_x_o           (out_x_o),
    .out_y_o           (out_y_o),
    .out_z_o           (out_z_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor copy of the register file
  logic [RowW-1:0]  mat_row [3];
  logic [DataW-1:0] offset  [3];

  vec_out_t expected_vecs[$];
  int n_errors     = 0;
  int n_items      = 0;
  int n_results    = 0;
  int n_reg_writes = 0;
  int n_settings   = 0;
  int in_gap_odds  = 0;  // percent chance of an input gap burst per item
  int stall_odds   = 0;  // percent chance of a stall burst per cycle
  int stall_left   = 0;
  int idle_cycles  = 0;

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t MISMATCH %s: got %h, want %h", $time, what, got, want);
    n_errors++;
  endtask

  function automatic logic [DataW-1:0] row_lane(logic [RowW-1:0] row, vec_item_t it,
                                                logic [DataW-1:0] t);
    logic [DataW-1:0] c [3];
    logic [DataW-1:0] acc;
    for (int k = 0; k < 3; k++) c[k] = DataW'($signed(row[k*CoefW +: CoefW]));
    acc = c[0] * it.x + c[1] * it.y + c[2] * it.z;  // wraps mod 2^32
    acc = DataW'($signed(acc) >>> FracW);
    if (it.flags.add_translation) acc = acc + t;
    if (it.flags.short_result) acc = DataW'($signed(acc[ShortW-1:0]));
    return acc;
  endfunction

  function automatic vec_out_t transform_vec(vec_item_t it);
    vec_out_t r;
    r.x = row_lane(mat_row[0], it, offset[0]);
    r.y = row_lane(mat_row[1], it, offset[1]);
    r.z = row_lane(mat_row[2], it, offset[2]);
    return r;
  endfunction

  // result checker and expectation store
  always @(posedge clk_i) begin
    vec_out_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_vecs.size() == 0) begin
          report("result with no item pending", 64'(out_x_o), '0);
        end else begin
          e = expected_vecs.pop_front();
          if (out_x_o !== e.x) report("out_x", 64'(out_x_o), 64'(e.x));
          if (out_y_o !== e.y) report("out_y", 64'(out_y_o), 64'(e.y));
          if (out_z_o !== e.z) report("out_z", 64'(out_z_o), 64'(e.z));
          n_results++;
        end
      end
      if (in_valid_i && !in_stall_o) begin
        expected_vecs.push_back(transform_vec({in_x_i, in_y_i, in_z_i,
                                               add_translation_i, short_result_i}));
        n_items++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable && pready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= StallLimit) begin
      $display("watchdog: %0d cycles without a transfer", StallLimit);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver back-pressure in bursts
  always @(negedge clk_i) begin
    if (stall_odds == 0) begin
      stall_left = 0;
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(1, 100) <= stall_odds) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_item(vec_item_t it);
    int gap;
    if (in_gap_odds != 0 && $urandom_range(1, 100) <= in_gap_odds) begin
      gap = $urandom_range(1, 9);
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i        <= 1'b1;
    in_x_i            <= it.x;
    in_y_i            <= it.y;
    in_z_i            <= it.z;
    add_translation_i <= it.flags.add_translation;
    short_result_i    <= it.flags.short_result;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_vec(logic [DataW-1:0] x, logic [DataW-1:0] y, logic [DataW-1:0] z,
                          logic add_t, logic shrt);
    send_item({x, y, z, add_t, shrt});
  endtask

  task automatic wait_results_done();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (expected_vecs.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [IdxW-1:0] idx, logic [PDataW-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, {IdxLsb{1'b0}}};
    pwdata  <= value;
    @(negedge clk_i) penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      q12mvt_pkg::RegRow0:   mat_row[0] = value[RowW-1:0];
      q12mvt_pkg::RegRow1:   mat_row[1] = value[RowW-1:0];
      q12mvt_pkg::RegRow2:   mat_row[2] = value[RowW-1:0];
      q12mvt_pkg::RegTransX: offset[0]  = value[DataW-1:0];
      q12mvt_pkg::RegTransY: offset[1]  = value[DataW-1:0];
      q12mvt_pkg::RegTransZ: offset[2]  = value[DataW-1:0];
      default: ;  // unmapped index: write dropped
    endcase
    n_reg_writes++;
  endtask

  task automatic apb_read(logic [IdxW-1:0] idx, output logic [PDataW-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, {IdxLsb{1'b0}}};
    @(negedge clk_i) penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // read back all registers; only the implemented width is compared
  task automatic check_regs();
    logic [PDataW-1:0] got;
    logic [PDataW-1:0] want;
    logic [PDataW-1:0] mask;
    for (int i = q12mvt_pkg::RegRow0; i <= q12mvt_pkg::RegTransZ; i++) begin
      apb_read(IdxW'(i), got);
      if (i <= q12mvt_pkg::RegRow2) begin
        want = PDataW'(mat_row[i - q12mvt_pkg::RegRow0]);
        mask = PDataW'({RowW{1'b1}});
      end else begin
        want = PDataW'(offset[i - q12mvt_pkg::RegTransX]);
        mask = PDataW'({DataW{1'b1}});
      end
      if ((got & mask) !== want) report($sformatf("register %0d readback", i), got, want);
    end
  endtask

  function automatic logic [DataW-1:0] pick_component();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return '0;
          1: return 32'sd1;
          2: return '1;
          3: return 32'h7fff_ffff;
          default: return 32'h8000_0000;
        endcase
      end
      1, 2, 3: return DataW'($signed(ShortW'($urandom)));  // short-vector input
      4, 5: return DataW'($urandom_range(0, 10000)) - 32'd5000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CoefW-1:0] pick_coef(int mode);
    if (mode == 1) return 16'h7fff;
    if (mode == 2) return 16'h8000;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 5))
          0: return 16'h7fff;
          1: return 16'h8000;
          2: return 16'h0000;
          3: return 16'h1000;
          4: return 16'hf000;
          default: return 16'hffff;
        endcase
      end
      1, 2: return CoefW'($urandom_range(0, 16384)) - 16'd8192;
      default: return CoefW'($urandom);
    endcase
  endfunction

  function automatic logic [DataW-1:0] pick_offset(int mode);
    if (mode == 1) return 32'h7fff_ffff;
    if (mode == 2) return 32'h8000_0000;
    if ($urandom_range(0, 5) == 0) return '0;
    return $urandom;
  endfunction

  // mode 1: all maximum, mode 2: all minimum, otherwise random
  task automatic load_config(int mode);
    logic [PDataW-1:0] junk;
    wait_results_done();
    for (int r = 0; r < 3; r++) begin
      junk = {$urandom, $urandom};  // upper bits must be dropped
      apb_write(IdxW'(q12mvt_pkg::RegRow0) + IdxW'(r),
                {junk[PDataW-1:RowW], pick_coef(mode), pick_coef(mode), pick_coef(mode)});
    end
    for (int r = 0; r < 3; r++) begin
      apb_write(IdxW'(q12mvt_pkg::RegTransX) + IdxW'(r), {$urandom, pick_offset(mode)});
    end
    check_regs();
    n_settings++;
  endtask

  function automatic vec_item_t random_item();
    vec_item_t it;
    it.x = pick_component();
    it.y = pick_component();
    it.z = pick_component();
    it.flags.add_translation = 1'($urandom_range(0, 1));
    it.flags.short_result = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic test_reset_state();
    check_regs();
    n_settings++;
    send_vec('0, '0, '0, 1'b0, 1'b0);
    send_vec(32'd1, '1, 32'h7fff_ffff, 1'b0, 1'b0);
    send_vec(32'h8000_0000, 32'h7fff_ffff, '1, 1'b0, 1'b1);
    send_vec(32'h1234_5678, 32'h0000_8000, 32'hffff_7fff, 1'b0, 1'b1);
    send_vec(32'd5, -32'sd5, 32'd7, 1'b1, 1'b0);
    send_vec('1, 32'h0001_0000, 32'hfff0_0000, 1'b1, 1'b1);
  endtask

  // saturated coefficients, wrapping translations, rounding of negative sums,
  // writes to unmapped indexes and to bits above a register's width
  task automatic test_directed_extremes();
    wait_results_done();
    apb_write(q12mvt_pkg::RegRow0, 64'hffff_7fff_7fff_7fff);
    apb_write(q12mvt_pkg::RegRow1, 64'hffff_8000_8000_8000);
    apb_write(q12mvt_pkg::RegRow2, 64'hffff_0000_ffff_0001);
    apb_write(q12mvt_pkg::RegTransX, 64'hffff_ffff_7fff_ffff);
    apb_write(q12mvt_pkg::RegTransY, 64'hffff_ffff_8000_0000);
    apb_write(q12mvt_pkg::RegTransZ, 64'hffff_ffff_ffff_ffff);
    apb_write(IdxW'(q12mvt_pkg::RegTransZ) + 1'b1, '1);
    apb_write(IdxW'(q12mvt_pkg::RegTransZ) + 2'd2, '1);
    check_regs();
    n_settings++;
    send_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1, 1'b0);
    send_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1);
    send_vec(32'd1, '0, '0, 1'b0, 1'b0);
    send_vec('1, '0, '0, 1'b0, 1'b0);   // sum -1 must floor to -1
    send_vec('0, 32'd1, '0, 1'b0, 1'b0);
    send_vec('1, '1, '1, 1'b0, 1'b1);
    send_vec('1, '1, '1, 1'b1, 1'b0);
    send_vec(32'h0000_7fff, 32'hffff_8000, 32'h0000_1000, 1'b1, 1'b1);
    send_vec(32'haaaa_aaaa, 32'h5555_5555, 32'hdead_beef, 1'b0, 1'b0);
    send_vec(32'h5555_5555, 32'haaaa_aaaa, 32'h0bad_f00d, 1'b1, 1'b1);
  endtask

  task automatic test_random_phases(int total);
    int done;
    int len;
    int pause_at;
    int phase;
    int odds [4] = '{0, 10, 30, 60};
    done  = 0;
    phase = 0;
    while (done < total) begin
      load_config(phase < 2 ? phase + 1 : 0);
      in_gap_odds = odds[$urandom_range(0, 3)];
      stall_odds  = odds[$urandom_range(0, 3)];
      len      = $urandom_range(60, 200);
      pause_at = $urandom_range(1, len - 1);
      for (int i = 0; i < len; i++) begin
        if (i == pause_at) wait_results_done();
        send_item(random_item());
      end
      done += len;
      phase++;
    end
  endtask

  // back-to-back items with the receiver never stalling
  task automatic test_full_rate(int count);
    load_config(0);
    in_gap_odds = 0;
    stall_odds  = 0;
    for (int i = 0; i < count; i++) send_item(random_item());
  endtask

  initial begin
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    in_x_i            = '0;
    in_y_i            = '0;
    in_z_i            = '0;
    add_translation_i = 1'b0;
    short_result_i    = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    mat_row[0] = q12mvt_pkg::Row0Reset;
    mat_row[1] = q12mvt_pkg::Row1Reset;
    mat_row[2] = q12mvt_pkg::Row2Reset;
    offset[0]  = '0;
    offset[1]  = '0;
    offset[2]  = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    test_reset_state();
    test_directed_extremes();
    test_random_phases(RandomItems);
    test_full_rate(SteadyItems);

    wait_results_done();
    repeat (4) @(posedge clk_i);
    $display("covered: %0d items, %0d results checked, %0d matrix/offset settings",
             n_items, n_results, n_settings);
    $display("register writes: %0d, including unmapped indexes and oversized data",
             n_reg_writes);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
